// File: rtl/skf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

   localparam int EST_W     = 32;
   localparam int COV_W     = 32;
   localparam int GAIN_W    = 31;
   localparam int FRAC_BITS = 30;
   localparam int DIV_STEPS = 30;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int REQ_W     = 64;
   localparam int RSP_W     = 96;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;

   localparam logic [CSR_IDX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_COVARIANCE = 2'd2;

   localparam logic [COV_W-1:0] PROCESS_NOISE_RESET      = 32'd1074;
   localparam logic [COV_W-1:0] MEASUREMENT_NOISE_RESET  = 32'd107374;
   localparam logic [COV_W-1:0] INITIAL_COVARIANCE_RESET = 32'd1073741824;

   typedef struct packed {
      logic capture;
      logic predict;
      logic prepare;
      logic div_step;
      logic multiply;
      logic finish;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/skf_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module skf_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output skf_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_PREPARE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   state_type                    state_ff;
   logic [skf_pkg::CNT_W-1:0]    count_ff;
   logic                         rsp_valid_ff;
   logic                         out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.predict  = (state_ff == ST_PREDICT);
      cmd.prepare  = (state_ff == ST_PREPARE);
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.multiply = (state_ff == ST_MULTIPLY);
      cmd.finish   = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) state_ff <= ST_PREDICT;
            end
            ST_PREDICT: begin
               state_ff <= ST_PREPARE;
            end
            ST_PREPARE: begin
               count_ff <= '0;
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (count_ff == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
                  state_ff <= ST_MULTIPLY;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            ST_MULTIPLY: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/skf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module skf_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire skf_pkg::cmd_type                cmd,
   input  wire logic [skf_pkg::REQ_W-1:0]       req_tdata,
   input  wire logic                            csr_we,
   input  wire logic [skf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [skf_pkg::CSR_W-1:0]       csr_wdata,
   output logic [skf_pkg::RSP_W-1:0]            rsp_tdata
);

   localparam int EW = skf_pkg::EST_W;
   localparam int CW = skf_pkg::COV_W;
   localparam int GW = skf_pkg::GAIN_W;
   localparam int FB = skf_pkg::FRAC_BITS;

   logic [CW-1:0]          q_noise_ff, r_noise_ff;
   logic signed [EW-1:0]   est_ff, est_in;
   logic [CW-1:0]          cov_ff, cov_in;
   logic signed [EW-1:0]   vel_ff, z_ff, proj_ff, proj_in;
   logic [CW-1:0]          pproj_ff, pproj_in;
   logic [CW:0]            den_ff, den_in;
   logic                   den_zero_ff;
   logic signed [EW:0]     innov_ff, innov_in;
   logic [CW:0]            rem_ff, rem_in;
   logic [GW-1:0]          quo_ff, quo_in;
   logic signed [63:0]     prod_ff;
   logic [62:0]            covprod_ff;
   logic [skf_pkg::RSP_W-1:0] rsp_ff;

   logic signed [EW:0]     est_sum;
   logic [CW:0]            cov_sum;
   logic [CW+1:0]          shifted;
   logic [CW+1:0]          diff;
   logic                   fits;
   logic signed [64:0]     prod_full;
   logic [GW-1:0]          one_minus;
   logic signed [63:0]     corr_t;
   logic signed [33:0]     corr;
   logic signed [34:0]     upd_sum;
   logic [62:0]            cov_t;
   logic [CW:0]            cov_sh;

   // predict
   always_comb begin
      est_sum = $signed({est_ff[EW-1], est_ff}) + $signed({vel_ff[EW-1], vel_ff});
      if (est_sum[EW] != est_sum[EW-1]) begin
         proj_in = est_sum[EW] ? $signed({1'b1, {(EW-1){1'b0}}})
                               : $signed({1'b0, {(EW-1){1'b1}}});
      end else begin
         proj_in = est_sum[EW-1:0];
      end
      cov_sum  = {1'b0, cov_ff} + {1'b0, q_noise_ff};
      pproj_in = cov_sum[CW] ? {CW{1'b1}} : cov_sum[CW-1:0];
   end

   // prepare and divide
   always_comb begin
      den_in   = {1'b0, pproj_ff} + {1'b0, r_noise_ff};
      innov_in = $signed({z_ff[EW-1], z_ff}) - $signed({proj_ff[EW-1], proj_ff});
      shifted  = {rem_ff, 1'b0};
      diff     = shifted - {1'b0, den_ff};
      fits     = (shifted >= {1'b0, den_ff}) && !den_zero_ff;
      if (cmd.prepare) begin
         rem_in = (r_noise_ff == '0) ? '0 : {1'b0, pproj_ff};
         quo_in = {{(GW-1){1'b0}}, (r_noise_ff == '0) && (pproj_ff != '0)};
      end else begin
         rem_in = fits ? diff[CW:0] : shifted[CW:0];
         quo_in = {quo_ff[GW-2:0], fits};
      end
   end

   // multiply
   assign prod_full = 65'($signed({1'b0, quo_ff})) * 65'(innov_ff);
   assign one_minus = {1'b1, {FB{1'b0}}} - quo_ff;

   // round and saturate
   always_comb begin
      corr_t  = prod_ff + $signed(64'd1 << (FB - 1));
      corr    = corr_t[63:FB];
      upd_sum = $signed({{3{proj_ff[EW-1]}}, proj_ff}) + $signed({corr[33], corr});
      if (upd_sum[34:EW-1] == '0 || upd_sum[34:EW-1] == '1) begin
         est_in = upd_sum[EW-1:0];
      end else begin
         est_in = upd_sum[34] ? $signed({1'b1, {(EW-1){1'b0}}})
                              : $signed({1'b0, {(EW-1){1'b1}}});
      end
      cov_t  = covprod_ff + (63'd1 << (FB - 1));
      cov_sh = cov_t[62:FB];
      cov_in = cov_sh[CW] ? {CW{1'b1}} : cov_sh[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_noise_ff  <= skf_pkg::PROCESS_NOISE_RESET;
         r_noise_ff  <= skf_pkg::MEASUREMENT_NOISE_RESET;
         est_ff      <= '0;
         cov_ff      <= skf_pkg::INITIAL_COVARIANCE_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               skf_pkg::REG_PROCESS_NOISE:      q_noise_ff <= csr_wdata;
               skf_pkg::REG_MEASUREMENT_NOISE:  r_noise_ff <= csr_wdata;
               skf_pkg::REG_INITIAL_COVARIANCE: begin
                  cov_ff      <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (cmd.finish) begin
            est_ff <= est_in;
            cov_ff <= cov_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vel_ff <= req_tdata[EW-1:0];
         z_ff   <= req_tdata[2*EW-1:EW];
      end
      if (cmd.predict) begin
         proj_ff  <= proj_in;
         pproj_ff <= pproj_in;
      end
      if (cmd.prepare) begin
         den_ff      <= den_in;
         den_zero_ff <= (den_in == '0);
         innov_ff    <= innov_in;
      end
      if (cmd.prepare || cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.multiply) begin
         prod_ff    <= prod_full[63:0];
         covprod_ff <= 63'(one_minus) * 63'(pproj_ff);
      end
      if (cmd.finish) begin
         rsp_ff <= {1'b0, cov_in, quo_ff, est_in};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/scalar_kalman_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Scalar Kalman filter, fixed point (estimates Q16.16, covariance UQ2.30, gain UQ1.30).
// Input words carry velocity and measurement; each one produces one output
// word with the corrected estimate, the gain and the new error covariance.
// Noise terms and the initial covariance are set through the csr write port
// while the block is idle; the user is bound to this, and the block itself
// does not enforce it. Writing the initial covariance also reloads the running
// covariance at once. An input word is taken only when the block is idle.
// Its result word shows on rsp in the same cycle that the next input can
// be taken. The gain comes from a radix-2 restoring divider retiring one
// quotient bit per cycle; the gain-times-innovation and covariance products
// are registered in the multiply step and rounded in the finish step after it.
// The result sits in an output register: a new word is accepted while it
// waits, and a finished computation holds in its final step until the
// receiver takes the old word.
// Reset (synchronous, active high) loads the register defaults, clears the
// estimate and sets the covariance to the initial covariance default.

module scalar_kalman_filter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // velocity [31:0], measurement [63:32]
   input  wire logic [skf_pkg::REQ_W-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // estimate [31:0], gain [62:32], error_covariance [94:63], zero [95]
   output logic [skf_pkg::RSP_W-1:0]            rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [skf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [skf_pkg::CSR_W-1:0]       csr_wdata
);

   skf_pkg::cmd_type cmd;

   skf_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   skf_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: rtl/skf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module skf_port_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [skf_pkg::RSP_W-1:0]       rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second req word taken while busy");

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[62:32] <= 31'h40000000) && !rsp_tdata[95])
      else $error("gain above one or padding set");

endmodule

bind scalar_kalman_filter skf_port_checker u_skf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: bench/skf_checker.sv
`timescale 1ns / 1ps

module skf_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   // velocity [31:0], measurement [63:32]
   input  wire logic [skf_pkg::REQ_W-1:0]       req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // estimate [31:0], gain [62:32], error_covariance [94:63], zero [95]
   input  wire logic [skf_pkg::RSP_W-1:0]       rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [skf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [skf_pkg::CSR_W-1:0]       csr_wdata,
   output int                                   fail_count,
   output int                                   pending
);

   typedef struct packed {
      logic signed [skf_pkg::EST_W-1:0] estimate;
      logic [skf_pkg::GAIN_W-1:0]       gain;
      logic [skf_pkg::COV_W-1:0]        error_covariance;
   } filter_word_type;

   localparam logic [63:0] ONE_Q30  = 64'd1 << skf_pkg::FRAC_BITS;
   localparam logic [63:0] HALF_Q30 = 64'd1 << (skf_pkg::FRAC_BITS - 1);
   localparam logic [63:0] COV_MAX  = 64'h0000_0000_FFFF_FFFF;

   logic [skf_pkg::COV_W-1:0]        q_noise;
   logic [skf_pkg::COV_W-1:0]        r_noise;
   logic [skf_pkg::COV_W-1:0]        p_init;
   logic signed [skf_pkg::EST_W-1:0] state_est;
   logic [skf_pkg::COV_W-1:0]        state_cov;

   filter_word_type predicted_outputs[$];
   int errors = 0;
   int reports = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic logic signed [skf_pkg::EST_W-1:0] clamp_s32(input longint v);
      if (v > 64'sd2147483647)
         return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648)
         return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic filter_word_type kalman_step(
         input logic signed [skf_pkg::EST_W-1:0] vel,
         input logic signed [skf_pkg::EST_W-1:0] z);
      filter_word_type res;
      longint proj;
      longint innov;
      longint g_s;
      longint corr;
      logic [63:0] pproj;
      logic [63:0] den;
      logic [63:0] gain;
      logic [63:0] cov;
      proj = longint'(state_est) + longint'(vel);
      proj = longint'(clamp_s32(proj));
      pproj = {32'd0, state_cov} + {32'd0, q_noise};
      if (pproj > COV_MAX)
         pproj = COV_MAX;
      den = pproj + {32'd0, r_noise};
      gain = (den == 64'd0) ? 64'd0 : (pproj << skf_pkg::FRAC_BITS) / den;
      if (gain > ONE_Q30)
         gain = ONE_Q30;
      innov = longint'(z) - proj;
      g_s = longint'(gain);
      corr = (g_s * innov + longint'(HALF_Q30)) >>> skf_pkg::FRAC_BITS;
      cov = ((ONE_Q30 - gain) * pproj + HALF_Q30) >> skf_pkg::FRAC_BITS;
      if (cov > COV_MAX)
         cov = COV_MAX;
      res.estimate = clamp_s32(proj + corr);
      res.gain = gain[skf_pkg::GAIN_W-1:0];
      res.error_covariance = cov[skf_pkg::COV_W-1:0];
      state_est = res.estimate;
      state_cov = res.error_covariance;
      return res;
   endfunction

   always @(posedge clock) begin
      filter_word_type want;
      filter_word_type got;
      if (reset) begin
         q_noise = skf_pkg::PROCESS_NOISE_RESET;
         r_noise = skf_pkg::MEASUREMENT_NOISE_RESET;
         p_init = skf_pkg::INITIAL_COVARIANCE_RESET;
         state_est = '0;
         state_cov = skf_pkg::INITIAL_COVARIANCE_RESET;
         predicted_outputs.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               skf_pkg::REG_PROCESS_NOISE: q_noise = csr_wdata;
               skf_pkg::REG_MEASUREMENT_NOISE: r_noise = csr_wdata;
               skf_pkg::REG_INITIAL_COVARIANCE: begin
                  p_init = csr_wdata;
                  state_cov = csr_wdata;
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.estimate = rsp_tdata[31:0];
            got.gain = rsp_tdata[62:32];
            got.error_covariance = rsp_tdata[94:63];
            if (predicted_outputs.size() == 0) begin
               errors++;
               if (reports < 10) begin
                  reports++;
                  $display("unexpected word: est=%h gain=%h cov=%h",
                           got.estimate, got.gain, got.error_covariance);
               end
            end else begin
               want = predicted_outputs.pop_front();
               if (got.estimate !== want.estimate || got.gain !== want.gain ||
                   got.error_covariance !== want.error_covariance) begin
                  errors++;
                  if (reports < 10) begin
                     reports++;
                     $display("mismatch: exp est=%h gain=%h cov=%h, got est=%h gain=%h cov=%h",
                              want.estimate, want.gain, want.error_covariance,
                              got.estimate, got.gain, got.error_covariance);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            predicted_outputs.push_back(kalman_step(req_tdata[31:0], req_tdata[63:32]));
      end
      pending <= predicted_outputs.size();
      fail_count <= errors;
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam logic [skf_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int STUCK_LIMIT = 3000;
   localparam int DRAIN_WAIT  = 40;
   localparam int RAND_PHASES = 9;
   localparam int PHASE_WORDS = 160;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [skf_pkg::REQ_W-1:0]     req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [skf_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          csr_we;
   logic [skf_pkg::CSR_IDX_W-1:0] csr_index;
   logic [skf_pkg::CSR_W-1:0]     csr_wdata;
   logic                          quiet;
   int                            fail_count;
   int                            pending;
   int                            rsp_seen;
   int                            stall_left;
   int                            stuck_cycles;

   scalar_kalman_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   skf_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet = 1'b0;
      rsp_seen = 0;
      stall_left = 0;
      stuck_cycles = 0;
   end

   // receiver: random backpressure plus two long hold-offs
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         rsp_seen <= rsp_seen + 1;
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_tvalid && rsp_tready && (rsp_seen == 400 || rsp_seen == 1000)) begin
         rsp_tready <= 1'b0;
         stall_left <= 300;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 6);
      end
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("scalar_kalman_filter verification failed");
      $finish;
   end

   task automatic send_word(input logic [31:0] vel, input logic [31:0] z);
      while (!quiet && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, vel};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [skf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [skf_pkg::CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (pending != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic load_noise(input logic [31:0] q, input logic [31:0] r, input logic [31:0] p0);
      csr_write(skf_pkg::REG_PROCESS_NOISE, q);
      csr_write(skf_pkg::REG_MEASUREMENT_NOISE, r);
      csr_write(skf_pkg::REG_INITIAL_COVARIANCE, p0);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] pick_noise(input int kind);
      case (kind)
         0: return $urandom_range(4096);
         1: return $urandom;
         2: return $urandom_range(32'h0100_0000);
         default: return 32'd0;
      endcase
   endfunction

   initial begin
      logic [31:0] dir_vel[16];
      logic [31:0] dir_z[16];
      logic [31:0] q;
      logic [31:0] r;
      logic [31:0] p0;
      logic [31:0] vel;
      logic [31:0] z;
      longint track;
      int pick;

      dir_vel = '{32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000,
                  32'h0, 32'h8000_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h5555_AAAA};
      dir_z   = '{32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'h0001_0000,
                  32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hAAAA_5555, 32'h0000_0001};
      track = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, ignored index, field extremes
      csr_write(REG_UNUSED, $urandom);
      load_noise(skf_pkg::PROCESS_NOISE_RESET, skf_pkg::MEASUREMENT_NOISE_RESET,
                 skf_pkg::INITIAL_COVARIANCE_RESET);
      for (int i = 0; i < 16; i++)
         send_word(dir_vel[i], dir_z[i]);
      drain();

      // zero denominator
      load_noise(32'd0, 32'd0, 32'd0);
      send_word(32'h0001_0000, 32'h7FFF_FFFF);
      send_word(32'h8000_0000, 32'h0);
      send_word($urandom, $urandom);
      drain();

      // covariance reload between phases keeps the estimate
      load_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(32'h0, 32'h7FFF_FFFF);
      send_word(32'h0, 32'h8000_0000);
      drain();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: begin
               q = 32'hFFFF_FFFF; r = 32'hFFFF_FFFF; p0 = 32'hFFFF_FFFF;
            end
            1: begin
               q = 32'd0; r = 32'd1; p0 = 32'hFFFF_FFFF;
            end
            2: begin
               q = 32'd0; r = 32'hFFFF_FFFF; p0 = 32'd0;
            end
            3: begin
               q = 32'hFFFF_FFFF; r = 32'd1; p0 = $urandom;
            end
            default: begin
               q = pick_noise($urandom_range(3));
               r = pick_noise($urandom_range(3));
               if (r == 32'd0)
                  r = 32'd1;
               p0 = $urandom_range(1) ? $urandom : $urandom_range(32'h4000_0000);
            end
         endcase
         load_noise(q, r, p0);
         quiet <= (ph == 5);
         track = 0;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               vel = $urandom;
               z = $urandom;
            end else if (pick < 15) begin
               vel = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               z = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
               vel = $urandom_range(32'h0002_0000) - 32'h0001_0000;
               track = track + longint'($signed(vel));
               if (track > 64'sd1073741824 || track < -64'sd1073741824)
                  track = 0;
               z = track[31:0] + ($urandom_range(32'h0000_8000) - 32'h0000_4000);
            end
            send_word(vel, z);
         end
         drain();
      end
      quiet <= 1'b0;

      if (fail_count == 0 && pending == 0)
         $display("scalar_kalman_filter verification clean");
      else
         $display("scalar_kalman_filter verification failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/skf_pkg.sv
rtl/skf_controller.sv
rtl/skf_datapath.sv
rtl/scalar_kalman_filter.sv
rtl/skf_checker.sv
bench/skf_checker.sv
bench/tb_top.sv
